>>> rtl/rbtt_pkg.sv
package rbtt_pkg;

  // Largest flow the bitmap can hold, in packets.
  localparam int MAX_PKTS = 1024;

  // The bitmap is kept as words of WORD_W packets each.
  localparam int WORD_W = 32;
  localparam int NWORDS = MAX_PKTS / WORD_W;
  localparam int WIDX_W = $clog2(NWORDS);
  localparam int BOFF_W = $clog2(WORD_W);

  // Field widths.
  localparam int SEQ_W     = 10;
  localparam int CNT_W     = 11;
  localparam int TOK_W     = 16;
  localparam int ECHO_W    = 17;
  localparam int GAP_W     = 18;
  localparam int CFG_IDX_W = 2;
  localparam int MOD_CNT_W = $clog2(CNT_W);

  localparam logic [CNT_W-1:0] MAX_PKTS_C = CNT_W'(MAX_PKTS);
  localparam logic [CNT_W-1:0] CNT_SAT    = {CNT_W{1'b1}};
  localparam logic [TOK_W-1:0] TOK_SAT    = {TOK_W{1'b1}};

  typedef logic [1:0] op_t;
  localparam op_t OP_DATA  = 2'd0;
  localparam op_t OP_TOKEN = 2'd1;
  localparam op_t OP_RELAX = 2'd2;
  localparam op_t OP_CLEAR = 2'd3;

  typedef logic [2:0] status_t;
  localparam status_t STAT_OK       = 3'd0;
  localparam status_t STAT_DUP      = 3'd1;
  localparam status_t STAT_COMPLETE = 3'd2;
  localparam status_t STAT_NOTHING  = 3'd3;
  localparam status_t STAT_NO_INIT  = 3'd4;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  localparam cfg_idx_t CFG_FLOW_SIZE   = 2'd0;
  localparam cfg_idx_t CFG_GOAL        = 2'd1;
  localparam cfg_idx_t CFG_TOKEN_WIN   = 2'd2;
  localparam cfg_idx_t CFG_SHORT_LIMIT = 2'd3;

  // Register values after reset.
  localparam logic [CNT_W-1:0] FLOW_SIZE_RST   = 11'd1;
  localparam logic [CNT_W-1:0] GOAL_RST        = 11'd1;
  localparam logic [CNT_W-1:0] TOKEN_WIN_RST   = 11'd1;
  localparam logic [CNT_W-1:0] SHORT_LIMIT_RST = 11'd8;

endpackage

>>> rtl/receive_bitmap_token_tracker_core.sv
// Flow: a data arrival reads and checks its bitmap word, marks a new packet, then walks
//   the frontier word by word (no walk for a duplicate or when the frontier already sits
//   at the limit); a token issue scans words from the restart point, first reducing that
//   point modulo the flow size when it lies past the flow; relax gap, clear and an empty
//   search range go straight to the output. Throughput: one item at a time, the next start
//   is taken in the cycle the result strobe is high. Each bitmap word costs one memory read.
// Reset: synchronous, active low; registers return to defaults, all tracker state clears.
module receive_bitmap_token_tracker_core (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  output logic                                 busy,
  input  rbtt_pkg::op_t                        in_op,
  input  logic [rbtt_pkg::SEQ_W-1:0]           in_pkt_num,
  input  logic [rbtt_pkg::TOK_W-1:0]           in_echo_tok,
  output logic                                 out_valid,
  output rbtt_pkg::status_t                    out_status,
  output logic [rbtt_pkg::CNT_W-1:0]           out_in_order_frontier,
  output logic [rbtt_pkg::CNT_W-1:0]           out_distinct_count,
  output logic                                 out_gap_within_window,
  output logic [rbtt_pkg::SEQ_W-1:0]           out_requested_seq,
  output logic [rbtt_pkg::TOK_W-1:0]           out_token_number,
  output logic [rbtt_pkg::CNT_W-1:0]           out_pkts_left,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  rbtt_pkg::cfg_idx_t                   cfg_index,
  input  logic [rbtt_pkg::CNT_W-1:0]           cfg_data
);

  import rbtt_pkg::*;

  // The sequencer walks each item through a few states. Bitmap accesses go through
  // the read state (address presented, data registered) and an evaluate state that
  // consumes the registered word, so a write always lands before any later read.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DRD,
    ST_DCHK,
    ST_MOD,
    ST_SRD,
    ST_SEV,
    ST_OUT
  } fsm_t;

  // What the shared word search is looking for.
  typedef enum logic [1:0] {
    MODE_FRONT,
    MODE_TOKA,
    MODE_TOKB
  } mode_t;

  fsm_t  state_r;
  mode_t mode_r;

  // Configuration registers.
  logic [CNT_W-1:0] flow_r;
  logic [CNT_W-1:0] goal_r;
  logic [CNT_W-1:0] window_r;
  logic [CNT_W-1:0] short_r;

  // Tracker state outside the bitmap.
  logic [CNT_W-1:0]         frontier_r;
  logic [CNT_W-1:0]         arrived_r;
  logic [TOK_W-1:0]         tokens_r;
  logic signed [ECHO_W-1:0] echo_r;
  logic [CNT_W-1:0]         last_req_r;
  logic                     started_r;

  // One valid bit per bitmap word; a word that is not valid reads as all clear.
  logic [NWORDS-1:0] row_vld_r;

  // Per-item context.
  op_t              op_r;
  logic [SEQ_W-1:0] dseq_r;
  logic             no_init_r;
  logic             dup_r;
  status_t          st_r;
  logic [SEQ_W-1:0] req_r;
  logic [TOK_W-1:0] tok_r;

  // Search window [p_r, e_r) and the token restart point.
  logic [CNT_W-1:0] p_r;
  logic [CNT_W-1:0] e_r;
  logic [CNT_W-1:0] s0_r;

  // Bit-serial remainder unit.
  logic [CNT_W-1:0]     v_r;
  logic [CNT_W-1:0]     rem_r;
  logic [MOD_CNT_W-1:0] mbit_r;

  // Registered result.
  logic             out_valid_r;
  status_t          out_status_r;
  logic [CNT_W-1:0] out_frontier_r;
  logic [CNT_W-1:0] out_count_r;
  logic             out_gap_r;
  logic [SEQ_W-1:0] out_req_r;
  logic [TOK_W-1:0] out_tok_r;
  logic [CNT_W-1:0] out_rem_r;

  // Bitmap memory.
  logic [WORD_W-1:0] mem [NWORDS];
  logic [WORD_W-1:0] mem_q_r;
  logic              rd_vld_r;
  logic              mem_re;
  logic [WIDX_W-1:0] mem_raddr;
  logic              mem_we;
  logic [WIDX_W-1:0] mem_waddr;
  logic [WORD_W-1:0] mem_wdata;

  // Combinational helpers.
  logic [CNT_W-1:0]          lim;
  logic [WORD_W-1:0]         word;
  logic                      bit_hit;
  logic [CNT_W-1:0]          vnext;
  logic [CNT_W-1:0]          rem_shift;
  logic [CNT_W-1:0]          rem_nxt;
  logic [WORD_W-1:0]         cand;
  logic                      found;
  logic [BOFF_W-1:0]         pos_off;
  logic [CNT_W-1:0]          pos;
  logic [CNT_W-1:0]          p_nxt;
  logic                      same_word;
  logic signed [GAP_W-1:0]   gap;
  logic                      gap_ok;
  logic [CNT_W-1:0]          rem_pkts;
  status_t                   data_status;
  logic signed [ECHO_W-1:0]  tseq_ext;
  logic signed [ECHO_W-1:0]  relax_echo;

  assign busy      = (state_r != ST_IDLE);
  assign cfg_ready = 1'b1;

  // Search limit is the flow size, capped at the bitmap size.
  assign lim = (flow_r < MAX_PKTS_C) ? flow_r : MAX_PKTS_C;

  // Memory port control. Reads happen only in the two read states; the single
  // write marks a new packet in the check state.
  always_comb begin
    mem_re    = (state_r == ST_DRD) || (state_r == ST_SRD);
    mem_raddr = (state_r == ST_DRD) ? dseq_r[SEQ_W-1:BOFF_W] : p_r[SEQ_W-1:BOFF_W];
  end

  assign word      = rd_vld_r ? mem_q_r : '0;
  assign bit_hit   = word[dseq_r[BOFF_W-1:0]];
  assign mem_we    = (state_r == ST_DCHK) && !bit_hit;
  assign mem_waddr = dseq_r[SEQ_W-1:BOFF_W];
  assign mem_wdata = word | (WORD_W'(1) << dseq_r[BOFF_W-1:0]);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_q_r  <= mem[mem_raddr];
      rd_vld_r <= row_vld_r[mem_raddr];
    end
  end

  // The restart point is one past the last requested packet. The reset value of
  // minus one wraps to zero in eleven bits.
  assign vnext = last_req_r + 11'd1;

  // One restoring remainder step: shift in the next dividend bit, subtract if it fits.
  assign rem_shift = {rem_r[CNT_W-2:0], v_r[CNT_W-1]};
  assign rem_nxt   = (rem_shift >= lim) ? (rem_shift - lim) : rem_shift;

  // Word search: clear bits at or above the start offset, and below the end of the
  // window if the window ends inside this word. The lowest such bit wins.
  assign same_word = (p_r[CNT_W-1:BOFF_W] == e_r[CNT_W-1:BOFF_W]);

  always_comb begin
    for (int j = 0; j < WORD_W; j++) begin
      cand[j] = !word[j] && (BOFF_W'(j) >= p_r[BOFF_W-1:0]) &&
                (!same_word || (BOFF_W'(j) < e_r[BOFF_W-1:0]));
    end
  end

  always_comb begin
    pos_off = '0;
    for (int j = WORD_W - 1; j >= 0; j--) begin
      if (cand[j]) begin
        pos_off = BOFF_W'(j);
      end
    end
  end

  assign found = |cand;
  assign pos   = {p_r[CNT_W-1:BOFF_W], pos_off};
  assign p_nxt = {p_r[CNT_W-1:BOFF_W] + 1'b1, {BOFF_W{1'b0}}};

  // Token gap is issued minus largest echo minus one, compared signed.
  assign gap    = $signed({2'b00, tokens_r}) - $signed({echo_r[ECHO_W-1], echo_r}) -
                  18'sd1;
  assign gap_ok = (gap <= $signed({7'b0000000, window_r}));

  assign rem_pkts = (flow_r > arrived_r) ? (flow_r - arrived_r) : '0;

  // A missing initial grant overrides everything; completion beats a duplicate.
  always_comb begin
    if (no_init_r) begin
      data_status = STAT_NO_INIT;
    end else if (arrived_r >= goal_r) begin
      data_status = STAT_COMPLETE;
    end else if (dup_r) begin
      data_status = STAT_DUP;
    end else begin
      data_status = STAT_OK;
    end
  end

  assign tseq_ext   = $signed({1'b0, in_echo_tok});
  assign relax_echo = $signed({1'b0, tokens_r}) - $signed({6'b000000, window_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      mode_r      <= MODE_FRONT;
      flow_r      <= FLOW_SIZE_RST;
      goal_r      <= GOAL_RST;
      window_r    <= TOKEN_WIN_RST;
      short_r     <= SHORT_LIMIT_RST;
      frontier_r  <= '0;
      arrived_r   <= '0;
      tokens_r    <= '0;
      echo_r      <= '1;
      last_req_r  <= '1;
      started_r   <= 1'b0;
      row_vld_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // The result strobe lasts exactly the cycle after the output state.
      out_valid_r <= (state_r == ST_OUT);

      // The user sends configuration beats only while the block is idle; it is not enforced.
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_FLOW_SIZE:   flow_r   <= cfg_data;
          CFG_GOAL:        goal_r   <= cfg_data;
          CFG_TOKEN_WIN:   window_r <= cfg_data;
          CFG_SHORT_LIMIT: short_r  <= cfg_data;
          default: ;
        endcase
      end

      case (state_r)
        ST_IDLE: begin
          if (start) begin
            op_r      <= in_op;
            dseq_r    <= in_pkt_num;
            // Only the first data packet of a flow that is too long (or empty) for an
            // initial grant is flagged.
            no_init_r <= (in_op == OP_DATA) && !started_r &&
                         !((flow_r != '0) && (flow_r <= short_r));
            dup_r     <= 1'b0;
            st_r      <= ((in_op == OP_TOKEN) && (lim == '0)) ? STAT_NOTHING : STAT_OK;
            req_r     <= '0;
            tok_r     <= '0;
            case (in_op)
              OP_DATA: begin
                // The first data packet either grants a short flow all its tokens
                // up front or flags that no initial tokens were given.
                if (!started_r) begin
                  started_r <= 1'b1;
                  if ((flow_r != '0) && (flow_r <= short_r)) begin
                    tokens_r   <= TOK_W'(flow_r);
                    last_req_r <= flow_r - 11'd1;
                  end
                end
                if (tseq_ext > echo_r) begin
                  echo_r <= tseq_ext;
                end
                state_r <= ST_DRD;
              end
              OP_TOKEN: begin
                if (lim == '0) begin
                  state_r <= ST_OUT;
                end else if (vnext < lim) begin
                  s0_r    <= vnext;
                  p_r     <= vnext;
                  e_r     <= lim;
                  mode_r  <= MODE_TOKA;
                  state_r <= ST_SRD;
                end else begin
                  // The restart point is past the flow, so reduce it modulo the size.
                  v_r     <= vnext;
                  rem_r   <= '0;
                  mbit_r  <= '0;
                  state_r <= ST_MOD;
                end
              end
              OP_RELAX: begin
                echo_r  <= relax_echo;
                state_r <= ST_OUT;
              end
              OP_CLEAR: begin
                frontier_r <= '0;
                arrived_r  <= '0;
                tokens_r   <= '0;
                echo_r     <= '1;
                last_req_r <= '1;
                started_r  <= 1'b0;
                row_vld_r  <= '0;
                state_r    <= ST_OUT;
              end
              default: state_r <= ST_OUT;
            endcase
          end
        end

        ST_DRD: begin
          state_r <= ST_DCHK;
        end

        ST_DCHK: begin
          if (bit_hit) begin
            dup_r   <= 1'b1;
            state_r <= ST_OUT;
          end else begin
            // The memory port writes the marked word at this edge.
            row_vld_r[dseq_r[SEQ_W-1:BOFF_W]] <= 1'b1;
            if (arrived_r != CNT_SAT) begin
              arrived_r <= arrived_r + 11'd1;
            end
            if (frontier_r < lim) begin
              p_r     <= frontier_r;
              e_r     <= lim;
              mode_r  <= MODE_FRONT;
              state_r <= ST_SRD;
            end else begin
              state_r <= ST_OUT;
            end
          end
        end

        ST_MOD: begin
          rem_r  <= rem_nxt;
          v_r    <= {v_r[CNT_W-2:0], 1'b0};
          mbit_r <= mbit_r + 1'b1;
          if (mbit_r == MOD_CNT_W'(CNT_W - 1)) begin
            s0_r    <= rem_nxt;
            p_r     <= rem_nxt;
            e_r     <= lim;
            mode_r  <= MODE_TOKA;
            state_r <= ST_SRD;
          end
        end

        ST_SRD: begin
          state_r <= ST_SEV;
        end

        ST_SEV: begin
          if (found) begin
            if (mode_r == MODE_FRONT) begin
              frontier_r <= pos;
            end else begin
              last_req_r <= pos;
              req_r      <= pos[SEQ_W-1:0];
              tok_r      <= tokens_r;
              if (tokens_r != TOK_SAT) begin
                tokens_r <= tokens_r + 16'd1;
              end
            end
            state_r <= ST_OUT;
          end else if (p_nxt >= e_r) begin
            // This window is exhausted.
            case (mode_r)
              MODE_FRONT: begin
                frontier_r <= e_r;
                state_r    <= ST_OUT;
              end
              MODE_TOKA: begin
                // Wrap to the frontier; everything below it is already marked, and
                // from the restart point up has just been searched.
                if (frontier_r < s0_r) begin
                  p_r     <= frontier_r;
                  e_r     <= s0_r;
                  mode_r  <= MODE_TOKB;
                  state_r <= ST_SRD;
                end else begin
                  st_r    <= STAT_NOTHING;
                  state_r <= ST_OUT;
                end
              end
              default: begin
                st_r    <= STAT_NOTHING;
                state_r <= ST_OUT;
              end
            endcase
          end else begin
            p_r     <= p_nxt;
            state_r <= ST_SRD;
          end
        end

        ST_OUT: begin
          out_status_r   <= (op_r == OP_DATA) ? data_status : st_r;
          out_frontier_r <= frontier_r;
          out_count_r    <= arrived_r;
          out_gap_r      <= gap_ok;
          out_req_r      <= req_r;
          out_tok_r      <= tok_r;
          out_rem_r      <= rem_pkts;
          state_r        <= ST_IDLE;
        end

        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_valid             = out_valid_r;
  assign out_status            = out_status_r;
  assign out_in_order_frontier = out_frontier_r;
  assign out_distinct_count    = out_count_r;
  assign out_gap_within_window = out_gap_r;
  assign out_requested_seq     = out_req_r;
  assign out_token_number      = out_tok_r;
  assign out_pkts_left         = out_rem_r;

  // An accepted item always makes the block busy in the cycle after it is accepted.
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted item did not make the block busy");

  // A result beat appears only as the block returns to idle.
  a_out_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result strobe while busy");

  // Each item produces a single result beat.
  a_out_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held for two cycles");

  // The search window is never empty when a word is evaluated.
  a_search_window: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SEV) |-> (p_r < e_r))
    else $error("word search evaluated with an empty window");

  // The frontier never runs past the bitmap.
  a_frontier_bound: assert property (@(posedge clk) disable iff (!rst_n)
    frontier_r <= MAX_PKTS_C)
    else $error("frontier beyond bitmap size");

endmodule

>>> verif/testbench.sv
module testbench;
  import rbtt_pkg::*;

  // No beat of any kind for this many cycles means the block has hung. The slowest
  // correct wait is a full-bitmap token search or a long sender gap.
  localparam int STALL_LIMIT  = 3000;
  localparam int DRAIN_CYCLES = 2;
  localparam int TAIL_CYCLES  = 40;
  localparam int RANDOM_CMDS  = 820;

  typedef struct {
    bit               is_write;
    op_t              op;
    logic [SEQ_W-1:0] pkt_num;
    logic [TOK_W-1:0] echo_tok;
    cfg_idx_t         reg_idx;
    logic [CNT_W-1:0] reg_value;
    int               gap;
  } tracker_cmd_t;

  typedef struct {
    status_t          status;
    logic [CNT_W-1:0] frontier;
    logic [CNT_W-1:0] distinct;
    logic             gap_ok;
    logic [SEQ_W-1:0] req_seq;
    logic [TOK_W-1:0] token_no;
    logic [CNT_W-1:0] remaining;
  } tracker_report_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             start = 1'b0;
  logic             busy;
  op_t              in_op = OP_DATA;
  logic [SEQ_W-1:0] in_pkt_num = '0;
  logic [TOK_W-1:0] in_echo_tok = '0;
  logic             out_valid;
  status_t          out_status;
  logic [CNT_W-1:0] out_in_order_frontier;
  logic [CNT_W-1:0] out_distinct_count;
  logic             out_gap_within_window;
  logic [SEQ_W-1:0] out_requested_seq;
  logic [TOK_W-1:0] out_token_number;
  logic [CNT_W-1:0] out_pkts_left;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  cfg_idx_t         cfg_index = CFG_FLOW_SIZE;
  logic [CNT_W-1:0] cfg_data = '0;

  receive_bitmap_token_tracker_core u_top (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .start                 (start),
    .busy                  (busy),
    .in_op                 (in_op),
    .in_pkt_num            (in_pkt_num),
    .in_echo_tok           (in_echo_tok),
    .out_valid             (out_valid),
    .out_status            (out_status),
    .out_in_order_frontier (out_in_order_frontier),
    .out_distinct_count    (out_distinct_count),
    .out_gap_within_window (out_gap_within_window),
    .out_requested_seq     (out_requested_seq),
    .out_token_number      (out_token_number),
    .out_pkts_left         (out_pkts_left),
    .cfg_valid             (cfg_valid),
    .cfg_ready             (cfg_ready),
    .cfg_index             (cfg_index),
    .cfg_data              (cfg_data)
  );

  always #6 clk = ~clk;

  // Commands waiting for the driver, and the reports predicted for accepted commands.
  tracker_cmd_t    tracker_items[$];
  tracker_report_t predicted_reports[$];

  // Our own copy of the registers and of the tracker state.
  int flow_size, goal, window, short_limit;
  bit pkt_seen[MAX_PKTS];
  int front, distinct, tokens_out, largest_echo, last_req;
  bit flow_started;

  // Handshake bookkeeping used by the clocked blocks.
  logic in_beat = 1'b0;
  logic cfg_beat = 1'b0;
  int   quiet_cycles = 0;
  int   stall_cycles = 0;
  int   hold_off = 0;

  // Stimulus generation state and run statistics.
  int burst_left = 0;
  bit steady_stream = 0;
  int random_cmds = 0;
  int mismatches = 0;
  int reports_checked = 0;
  int cmds_done = 0;
  int writes_done = 0;
  int status_seen[8];

  function automatic void clear_tracker();
    foreach (pkt_seen[i]) pkt_seen[i] = 1'b0;
    front = 0;
    distinct = 0;
    tokens_out = 0;
    largest_echo = -1;
    last_req = -1;
    flow_started = 1'b0;
  endfunction

  function automatic void apply_write(cfg_idx_t idx, logic [CNT_W-1:0] value);
    case (idx)
      CFG_FLOW_SIZE:   flow_size = value;
      CFG_GOAL:        goal = value;
      CFG_TOKEN_WIN:   window = value;
      CFG_SHORT_LIMIT: short_limit = value;
      default: ;
    endcase
  endfunction

  // Works out the report for one command and advances the tracker copy.
  function automatic tracker_report_t track_command(op_t op, logic [SEQ_W-1:0] dseq,
                                                    logic [TOK_W-1:0] tseq);
    tracker_report_t r;
    bit no_init, dup, found;
    int lim, n, s, steps, gap;
    no_init = 1'b0;
    dup = 1'b0;
    found = 1'b0;
    r.status = STAT_OK;
    r.req_seq = '0;
    r.token_no = '0;
    case (op)
      OP_DATA: begin
        // A short flow gets all of its tokens with the first data packet.
        if (!flow_started) begin
          flow_started = 1'b1;
          if (flow_size != 0 && flow_size <= short_limit) begin
            tokens_out = flow_size;
            last_req = flow_size - 1;
          end else begin
            no_init = 1'b1;
          end
        end
        if (pkt_seen[dseq]) begin
          dup = 1'b1;
        end else begin
          lim = (flow_size < MAX_PKTS) ? flow_size : MAX_PKTS;
          pkt_seen[dseq] = 1'b1;
          if (distinct < int'(CNT_SAT)) distinct++;
          while (front < lim && pkt_seen[front]) front++;
        end
        if (int'(tseq) > largest_echo) largest_echo = int'(tseq);
        if (distinct >= goal) r.status = STAT_COMPLETE;
        else if (dup) r.status = STAT_DUP;
        if (no_init) r.status = STAT_NO_INIT;
      end
      OP_TOKEN: begin
        // Next missing packet after the last one asked for, wrapping to the frontier.
        n = (flow_size < MAX_PKTS) ? flow_size : MAX_PKTS;
        s = 0;
        if (n != 0) begin
          steps = 0;
          s = (last_req + 1) % n;
          while (steps < n) begin
            if (!pkt_seen[s]) begin
              found = 1'b1;
              break;
            end
            s++;
            if (s >= n) begin
              s = front;
              if (s >= n) break;
            end
            steps++;
          end
        end
        if (found) begin
          last_req = s;
          r.req_seq = SEQ_W'(s);
          r.token_no = TOK_W'(tokens_out);
          if (tokens_out < int'(TOK_SAT)) tokens_out++;
        end else begin
          r.status = STAT_NOTHING;
        end
      end
      OP_RELAX: largest_echo = tokens_out - window;
      default:  clear_tracker();
    endcase
    gap = tokens_out - largest_echo - 1;
    r.frontier = CNT_W'(front);
    r.distinct = CNT_W'(distinct);
    r.gap_ok = (gap <= window);
    r.remaining = CNT_W'((flow_size > distinct) ? flow_size - distinct : 0);
    return r;
  endfunction

  task automatic report_mismatch(string msg);
    mismatches++;
    $display("MISMATCH: %s", msg);
  endtask

  task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("report %0d: %s is %0d, predicted %0d",
                                reports_checked, name, got, want));
    end
  endtask

  // Sender gaps: mostly none or short, a few long, and now and then a burst with none.
  function automatic int pick_gap();
    int roll;
    if (steady_stream) return 0;
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    roll = $urandom_range(0, 99);
    if (roll < 5) begin
      burst_left = $urandom_range(10, 40);
      return 0;
    end
    if (roll < 55) return 0;
    if (roll < 88) return $urandom_range(1, 3);
    if (roll < 96) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  task automatic add_cmd(op_t op, int dseq, int tseq);
    tracker_cmd_t c;
    c.is_write = 1'b0;
    c.op = op;
    c.pkt_num = SEQ_W'(dseq);
    c.echo_tok = TOK_W'((tseq > 65535) ? 65535 : tseq);
    c.reg_idx = CFG_FLOW_SIZE;
    c.reg_value = '0;
    c.gap = pick_gap();
    tracker_items.insert(tracker_items.size(), c);
  endtask

  task automatic add_write(cfg_idx_t idx, int value);
    tracker_cmd_t c;
    c.is_write = 1'b1;
    c.op = OP_DATA;
    c.pkt_num = '0;
    c.echo_tok = '0;
    c.reg_idx = idx;
    c.reg_value = CNT_W'((value > 2047) ? 2047 : value);
    c.gap = 0;
    tracker_items.insert(tracker_items.size(), c);
  endtask

  // One phase: new register settings, usually a clear, then a mix of well-formed
  // traffic (packets inside the flow, echoes near the issued token count) and noise.
  task automatic add_random_phase(int n_cmds);
    int flow, lim, tok_guess, roll, pick;
    roll = $urandom_range(0, 99);
    if (roll < 60) flow = $urandom_range(1, 40);
    else if (roll < 75) flow = $urandom_range(41, 300);
    else if (roll < 82) flow = MAX_PKTS;
    else if (roll < 87) flow = 2047;
    else if (roll < 92) flow = 0;
    else flow = $urandom_range(0, 2047);
    add_write(CFG_FLOW_SIZE, flow);
    if ($urandom_range(0, 4) != 0) begin
      roll = $urandom_range(0, 9);
      add_write(CFG_GOAL, (roll == 0) ? 0 : (roll == 1) ? 2047 : $urandom_range(1, flow + 2));
    end
    if ($urandom_range(0, 4) != 0) begin
      roll = $urandom_range(0, 9);
      add_write(CFG_TOKEN_WIN, (roll < 7) ? $urandom_range(0, 6) :
                               (roll == 7) ? 2047 : $urandom_range(0, 2047));
    end
    roll = $urandom_range(0, 9);
    if (roll < 4) add_write(CFG_SHORT_LIMIT, flow + $urandom_range(0, 3));
    else if (roll < 6) add_write(CFG_SHORT_LIMIT, (flow > 0) ? flow - 1 : 0);
    else if (roll == 6) add_write(CFG_SHORT_LIMIT, 0);
    else if (roll == 7) add_write(CFG_SHORT_LIMIT, 2047);
    else add_write(CFG_SHORT_LIMIT, $urandom_range(0, 64));
    if ($urandom_range(0, 5) != 0) add_cmd(OP_CLEAR, 0, 0);
    lim = (flow == 0 || flow > MAX_PKTS) ? MAX_PKTS : flow;
    tok_guess = flow;
    repeat (n_cmds) begin
      roll = $urandom_range(0, 99);
      pick = $urandom_range(0, 99);
      if (roll < 55) begin
        add_cmd(OP_DATA,
                (roll < 50) ? $urandom_range(0, lim - 1) : $urandom_range(0, MAX_PKTS - 1),
                (pick < 70) ? $urandom_range(0, tok_guess + 3) :
                (pick < 85) ? $urandom_range(0, 65535) :
                (pick < 93) ? 65535 : 0);
      end else if (roll < 87) begin
        add_cmd(OP_TOKEN, $urandom_range(0, MAX_PKTS - 1), $urandom_range(0, 65535));
        tok_guess++;
      end else if (roll < 95) begin
        add_cmd(OP_RELAX, $urandom_range(0, MAX_PKTS - 1), $urandom_range(0, 65535));
      end else begin
        add_cmd(OP_CLEAR, $urandom_range(0, MAX_PKTS - 1), $urandom_range(0, 65535));
      end
      random_cmds++;
    end
  endtask

  // Driver: a command beat or a register write is put up at the falling edge and held
  // until it is taken. Register writes wait until every predicted report has come back.
  always @(negedge clk) begin : drive_items
    tracker_cmd_t c;
    logic nxt_start, nxt_cfg;
    nxt_start = start && !in_beat;
    nxt_cfg = cfg_valid && !cfg_beat;
    if (rst_n && !nxt_start && !nxt_cfg && tracker_items.size() != 0) begin
      if (tracker_items[0].is_write) begin
        if (predicted_reports.size() == 0 && quiet_cycles >= DRAIN_CYCLES) begin
          c = tracker_items[0];
          tracker_items.delete(0);
          cfg_index <= c.reg_idx;
          cfg_data <= c.reg_value;
          nxt_cfg = 1'b1;
        end
      end else if (hold_off < tracker_items[0].gap) begin
        hold_off++;
      end else begin
        c = tracker_items[0];
        tracker_items.delete(0);
        in_op <= c.op;
        in_pkt_num <= c.pkt_num;
        in_echo_tok <= c.echo_tok;
        nxt_start = 1'b1;
        hold_off = 0;
      end
    end
    start <= nxt_start;
    cfg_valid <= nxt_cfg;
  end

  // Monitor and predictor: results are checked against the oldest prediction, and
  // every accepted command or register write updates the tracker copy.
  always @(posedge clk) begin : watch_results
    tracker_report_t want;
    if (rst_n) begin
      if (out_valid) begin
        if (predicted_reports.size() == 0) begin
          report_mismatch($sformatf("result strobe with nothing outstanding, status %0d",
                                    out_status));
        end else begin
          want = predicted_reports[0];
          predicted_reports.delete(0);
          reports_checked++;
          status_seen[want.status]++;
          check_field("status", 32'(out_status), 32'(want.status));
          check_field("in_order_frontier", 32'(out_in_order_frontier),
                      32'(want.frontier));
          check_field("distinct_count", 32'(out_distinct_count), 32'(want.distinct));
          check_field("gap_within_window", 32'(out_gap_within_window),
                      32'(want.gap_ok));
          check_field("requested_seq", 32'(out_requested_seq), 32'(want.req_seq));
          check_field("token_number", 32'(out_token_number), 32'(want.token_no));
          check_field("pkts_left", 32'(out_pkts_left), 32'(want.remaining));
        end
      end
      if (cfg_valid && cfg_ready) begin
        apply_write(cfg_index, cfg_data);
        writes_done++;
      end
      if (start && !busy) begin
        predicted_reports.insert(predicted_reports.size(),
                                 track_command(in_op, in_pkt_num, in_echo_tok));
        cmds_done++;
      end
    end
    in_beat <= rst_n && start && !busy;
    cfg_beat <= rst_n && cfg_valid && cfg_ready;
    quiet_cycles <= ((start && !busy) || out_valid) ? 0 : quiet_cycles + 1;
  end

  always @(posedge clk) begin : watchdog
    if (!rst_n || (start && !busy) || (cfg_valid && cfg_ready) || out_valid) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("Watchdog: no beat for %0d cycles, %0d commands still queued",
               stall_cycles, tracker_items.size());
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin : run
    flow_size = FLOW_SIZE_RST;
    goal = GOAL_RST;
    window = TOKEN_WIN_RST;
    short_limit = SHORT_LIMIT_RST;
    clear_tracker();

    // Directed: a short flow with initial tokens, a duplicate, the largest echo,
    // a packet beyond the flow, wrapping token requests, relax, completion, clear.
    add_write(CFG_FLOW_SIZE, 8);
    add_write(CFG_GOAL, 4);
    add_write(CFG_TOKEN_WIN, 2);
    add_write(CFG_SHORT_LIMIT, 8);
    add_cmd(OP_DATA, 3, 0);
    add_cmd(OP_DATA, 3, 5);
    add_cmd(OP_DATA, 0, 65535);
    add_cmd(OP_DATA, MAX_PKTS - 1, 1);
    repeat (3) add_cmd(OP_TOKEN, 0, 0);
    add_cmd(OP_RELAX, 0, 0);
    add_cmd(OP_DATA, 1, 3);
    add_cmd(OP_DATA, 1, 2);
    add_cmd(OP_TOKEN, 0, 0);
    add_cmd(OP_CLEAR, 0, 0);
    add_cmd(OP_TOKEN, 0, 0);
    // A flow too long for initial tokens, then an empty flow with nothing to request.
    add_write(CFG_FLOW_SIZE, 20);
    add_write(CFG_SHORT_LIMIT, 10);
    add_cmd(OP_DATA, 5, 0);
    add_cmd(OP_TOKEN, 0, 0);
    add_write(CFG_FLOW_SIZE, 0);
    add_cmd(OP_CLEAR, 0, 0);
    add_cmd(OP_TOKEN, 0, 0);
    add_cmd(OP_DATA, 0, 0);
    add_cmd(OP_TOKEN, 0, 0);
    // A two-packet flow filled completely, then the largest flow the bitmap holds.
    add_write(CFG_FLOW_SIZE, 2);
    add_write(CFG_GOAL, 2047);
    add_write(CFG_TOKEN_WIN, 0);
    add_write(CFG_SHORT_LIMIT, 2047);
    add_cmd(OP_CLEAR, 0, 0);
    add_cmd(OP_DATA, 0, 0);
    add_cmd(OP_DATA, 1, 0);
    add_cmd(OP_TOKEN, 0, 0);
    add_write(CFG_FLOW_SIZE, MAX_PKTS);
    add_write(CFG_GOAL, MAX_PKTS);
    add_write(CFG_TOKEN_WIN, 2047);
    add_write(CFG_SHORT_LIMIT, MAX_PKTS);
    add_cmd(OP_CLEAR, 0, 0);
    add_cmd(OP_DATA, MAX_PKTS - 1, 65535);
    add_cmd(OP_TOKEN, 0, 0);

    while (random_cmds < RANDOM_CMDS) add_random_phase($urandom_range(10, 60));

    // A back-to-back run of token requests on a nearly empty flow that started with
    // the largest initial grant a register allows, so the restart point lies past
    // the bitmap and has to be reduced first.
    steady_stream = 1'b1;
    add_write(CFG_FLOW_SIZE, 2047);
    add_write(CFG_GOAL, 1);
    add_write(CFG_TOKEN_WIN, 0);
    add_write(CFG_SHORT_LIMIT, 2047);
    add_cmd(OP_CLEAR, 0, 0);
    add_cmd(OP_DATA, 0, 0);
    repeat (16) add_cmd(OP_TOKEN, 0, 0);
    add_cmd(OP_RELAX, 0, 0);
    add_cmd(OP_TOKEN, 0, 0);
    add_cmd(OP_DATA, 5, 65535);

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (tracker_items.size() != 0 || start || cfg_valid || predicted_reports.size() != 0)
      @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    @(negedge clk);
    if (predicted_reports.size() != 0) begin
      report_mismatch($sformatf("%0d predicted reports never arrived",
                                predicted_reports.size()));
    end

    $display("Checked %0d reports for %0d commands across %0d register writes.",
             reports_checked, cmds_done, writes_done);
    $display("Status mix: ok %0d, duplicate %0d, complete %0d, none missing %0d, %s %0d.",
             status_seen[STAT_OK], status_seen[STAT_DUP], status_seen[STAT_COMPLETE],
             status_seen[STAT_NOTHING], "no initial tokens", status_seen[STAT_NO_INIT]);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
